@@ hw/rtl/m3au_pkg.sv @@
// shared types, operation codes and saturation helper for the 3x3 arithmetic unit
package m3au_pkg;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MMUL = 3'd2;
	localparam logic [2:0] OP_SADD = 3'd3;
	localparam logic [2:0] OP_SSUB = 3'd4;
	localparam logic [2:0] OP_SMUL = 3'd5;
	localparam logic [2:0] OP_SDIV = 3'd6;

	localparam logic REG_OP_MODE = 1'b0;
	localparam logic REG_SCALAR  = 1'b1;

	localparam logic [2:0]  OP_MODE_RESET = OP_MMUL;
	localparam logic [31:0] SCALAR_RESET  = 32'h0001_0000;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [31:0] a_element;
		logic signed [31:0] b_element;
	} in_t;

	typedef struct packed {
		logic signed [31:0] result_element;
		logic               last_element;
		logic               saturated;
	} out_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               sat;
	} clamp_t;

	function automatic clamp_t sat32(input logic signed [63:0] x);
		clamp_t r;
		if (x > 64'(Q_MAX)) begin
			r.value = Q_MAX;
			r.sat   = 1'b1;
		end else if (x < 64'(Q_MIN)) begin
			r.value = Q_MIN;
			r.sat   = 1'b1;
		end else begin
			r.value = x[31:0];
			r.sat   = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/matrix3_arith_unit_top.sv @@
// matrix3_arith_unit_top: element-wise, scalar and matrix product unit over DIM x DIM matrices
//
// usage: feed DIM*DIM input beats on in_data (one element of A and one of B each,
// row-major, signed Q16.16). in_ready is high while loading, one beat per cycle.
// the beat that completes the matrices starts the computation; in_ready drops
// until all DIM*DIM result beats have left on out_data, the last one marked.
// op_mode and scalar_value are written through cfg_we / cfg_index / cfg_data.
// steps per result element, through the single shared 32x32 multiplier and the
// one-bit-per-cycle divider, then the output state, held while out_ready is low:
//   add, subtract, scalar add/subtract, mode 7: read, execute
//   scalar multiply: read, execute, accumulate
//   matrix product: read, execute, accumulate, repeated for each of the DIM terms
//   scalar divide: read, execute, divide (one quotient bit per step), finish;
//   with a zero divisor it goes from execute straight to output.
// a stalled receiver holds the result register and the sequencer waits on it.
// reset clears the load count and sequencer, op_mode goes to matrix product
// and scalar_value to 1.0; the element stores are not cleared.
module matrix3_arith_unit_top
	import m3au_pkg::*;
#(
	parameter int DIM = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data
);

	localparam int CELLS = DIM * DIM;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(DIM);
	localparam logic [3:0]    CELLS_WRAP = 4'(CELLS);
	localparam logic [CW-1:0] LAST_IDX   = CW'(DIM - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EX   = 3'd2;
	localparam logic [2:0] S_ACC  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_DFIN = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]  state_q;
	logic [2:0]  op_mode_q;
	logic [31:0] scalar_q;
	logic [3:0]  load_cnt_q;
	logic [CW-1:0] row_q, col_q, k_q;

	logic [31:0] a_mem [CELLS];
	logic [31:0] b_mem [CELLS];
	logic signed [31:0] rd_a, rd_b;
	logic [AW-1:0] a_addr, b_addr;

	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;
	logic [47:0] dvd_q;
	logic [47:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic        neg_q;
	logic [5:0]  div_cnt_q;
	out_t        out_q;

	logic        is_mmul;
	logic [3:0]  load_next;
	logic signed [31:0] op_b;
	logic signed [32:0] addsub;
	logic signed [63:0] acc_next;
	logic [32:0] rem2;
	logic        rem_ge;
	logic signed [48:0] quo_signed;
	logic        last_cell;
	logic [31:0] abs_a, abs_s;

	assign is_mmul   = op_mode_q == OP_MMUL;
	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign out_data  = out_q;
	assign load_next = load_cnt_q + 4'd1;
	assign last_cell = (row_q == LAST_IDX) && (col_q == LAST_IDX);

	assign a_addr = is_mmul ? AW'(row_q) * AW'(DIM) + AW'(k_q)
	                        : AW'(row_q) * AW'(DIM) + AW'(col_q);
	assign b_addr = is_mmul ? AW'(k_q) * AW'(DIM) + AW'(col_q)
	                        : AW'(row_q) * AW'(DIM) + AW'(col_q);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			a_mem[load_cnt_q[AW-1:0]] <= in_data.a_element;
			b_mem[load_cnt_q[AW-1:0]] <= in_data.b_element;
		end
		rd_a <= a_mem[a_addr];
		rd_b <= b_mem[b_addr];
	end

	// second operand: stored B element or the scalar register
	always_comb begin
		op_b = (op_mode_q == OP_ADD || op_mode_q == OP_SUB || is_mmul)
		       ? rd_b : scalar_q;
		if (op_mode_q == OP_SUB || op_mode_q == OP_SSUB) begin
			addsub = 33'(rd_a) - 33'(op_b);
		end else begin
			addsub = 33'(rd_a) + 33'(op_b);
		end
		acc_next   = acc_q + (prod_q >>> 16);
		rem2       = {rem_q, dvd_q[47]};
		rem_ge     = rem2 >= {1'b0, dsr_q};
		quo_signed = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		abs_a      = rd_a[31] ? 32'd0 - rd_a : rd_a;
		abs_s      = scalar_q[31] ? 32'd0 - scalar_q : scalar_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q <= OP_MODE_RESET;
			scalar_q  <= SCALAR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OP_MODE: op_mode_q <= cfg_data[2:0];
				REG_SCALAR:  scalar_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			load_cnt_q <= 4'd0;
			row_q      <= '0;
			col_q      <= '0;
			k_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (load_next == CELLS_WRAP) begin
							load_cnt_q <= 4'd0;
							row_q      <= '0;
							col_q      <= '0;
							k_q        <= '0;
							state_q    <= S_RD;
						end else begin
							load_cnt_q <= load_next;
						end
					end
				end
				S_RD: state_q <= S_EX;
				S_EX: begin
					case (op_mode_q)
						OP_MMUL, OP_SMUL: state_q <= S_ACC;
						OP_SDIV:          state_q <= (scalar_q == 32'd0) ? S_OUT : S_DIV;
						default:          state_q <= S_OUT;
					endcase
				end
				S_ACC: begin
					if (is_mmul && k_q != LAST_IDX) begin
						k_q     <= k_q + CW'(1);
						state_q <= S_RD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (div_cnt_q == 6'd47) begin
						state_q <= S_DFIN;
					end
				end
				S_DFIN: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) begin
						k_q <= '0;
						if (last_cell) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RD;
							if (col_q == LAST_IDX) begin
								col_q <= '0;
								row_q <= row_q + CW'(1);
							end else begin
								col_q <= col_q + CW'(1);
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: shared multiplier, accumulator, restoring divider, result register
	always_ff @(posedge clk) begin
		case (state_q)
			S_EX: begin
				prod_q <= 64'(rd_a) * 64'(op_b);
				if (k_q == '0) begin
					acc_q <= '0;
				end
				out_q.last_element <= last_cell;
				case (op_mode_q)
					OP_ADD, OP_SUB, OP_SADD, OP_SSUB: begin
						{out_q.result_element, out_q.saturated} <= sat32(64'(addsub));
					end
					OP_SDIV: begin
						// zero divisor clamps by the sign of the element
						out_q.result_element <= rd_a[31] ? Q_MIN : Q_MAX;
						out_q.saturated      <= 1'b1;
						dvd_q     <= {abs_a, 16'd0};
						dsr_q     <= abs_s;
						rem_q     <= '0;
						quo_q     <= '0;
						neg_q     <= rd_a[31] ^ scalar_q[31];
						div_cnt_q <= '0;
					end
					OP_MMUL, OP_SMUL: ;
					default: begin
						out_q.result_element <= '0;
						out_q.saturated      <= 1'b0;
					end
				endcase
			end
			S_ACC: begin
				acc_q <= acc_next;
				{out_q.result_element, out_q.saturated} <= sat32(acc_next);
			end
			S_DIV: begin
				rem_q     <= rem_ge ? 32'(rem2 - {1'b0, dsr_q}) : rem2[31:0];
				quo_q     <= {quo_q[46:0], rem_ge};
				dvd_q     <= {dvd_q[46:0], 1'b0};
				div_cnt_q <= div_cnt_q + 6'd1;
			end
			S_DFIN: begin
				{out_q.result_element, out_q.saturated} <= sat32(64'(quo_signed));
			end
			default: ;
		endcase
	end

endmodule

@@ dv/tb_matrix3_arith_unit_top.sv @@
// testbench for the 3x3 matrix arithmetic unit: random and directed matrices, self-checking
`timescale 1ns / 1ps

module tb_matrix3_arith_unit_top
	import m3au_pkg::*;
();

	localparam int DIM = 3;
	localparam int CELLS = DIM * DIM;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;

	matrix3_arith_unit_top #(.DIM(DIM)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	in_t  pending_items[$];
	out_t expected_cells[$];

	// shadow of the unit's registers and element stores
	logic [2:0]         model_mode;
	logic signed [31:0] model_scalar;
	logic signed [31:0] a_cells[CELLS];
	logic signed [31:0] b_cells[CELLS];
	int                 loaded;

	int  send_idle;
	int  recv_idle;
	bit  hold_request;
	int  hold_left;
	bit  beat_taken;
	int  mismatches;
	int  quiet_cycles;

	function automatic out_t clamp_cell(input longint x, input bit div_sat);
		out_t r;
		r.last_element = 1'b0;
		r.saturated    = div_sat;
		if (x > longint'(Q_MAX)) begin
			r.result_element = Q_MAX;
			r.saturated      = 1'b1;
		end else if (x < longint'(Q_MIN)) begin
			r.result_element = Q_MIN;
			r.saturated      = 1'b1;
		end else begin
			r.result_element = x[31:0];
		end
		return r;
	endfunction

	function automatic out_t matrix_cell(input int r, input int c);
		longint a, b, s, acc;
		out_t   o;
		a = a_cells[r * DIM + c];
		b = b_cells[r * DIM + c];
		s = model_scalar;
		acc = 0;
		case (model_mode)
			OP_ADD:  o = clamp_cell(a + b, 1'b0);
			OP_SUB:  o = clamp_cell(a - b, 1'b0);
			OP_MMUL: begin
				for (int k = 0; k < DIM; k++)
					acc += (longint'(a_cells[r * DIM + k]) * longint'(b_cells[k * DIM + c])) >>> 16;
				o = clamp_cell(acc, 1'b0);
			end
			OP_SADD: o = clamp_cell(a + s, 1'b0);
			OP_SSUB: o = clamp_cell(a - s, 1'b0);
			OP_SMUL: o = clamp_cell((a * s) >>> 16, 1'b0);
			OP_SDIV: begin
				// zero divisor saturates toward the sign of the element
				if (s == 0)
					o = clamp_cell(a < 0 ? longint'(Q_MIN) : longint'(Q_MAX), 1'b1);
				else
					o = clamp_cell((a * 65536) / s, 1'b0);
			end
			default: o = clamp_cell(0, 1'b0);
		endcase
		o.last_element = (r == DIM - 1) && (c == DIM - 1);
		return o;
	endfunction

	task automatic store_beat(input in_t item);
		a_cells[loaded] = item.a_element;
		b_cells[loaded] = item.b_element;
		loaded++;
		if (loaded == CELLS) begin
			loaded = 0;
			for (int r = 0; r < DIM; r++)
				for (int c = 0; c < DIM; c++)
					expected_cells.push_back(matrix_cell(r, c));
		end
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !beat_taken) begin
			in_valid <= 1'b1;
		end else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
			in_data  <= pending_items.pop_front();
			in_valid <= 1'b1;
		end else begin
			in_valid <= 1'b0;
		end
		beat_taken = 1'b0;
	end

	// receiver, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		out_t want;
		bit   moved;
		moved = 1'b0;
		if (arst_n && in_valid && in_ready) begin
			beat_taken = 1'b1;
			moved = 1'b1;
			store_beat(in_data);
		end
		if (arst_n && out_valid && out_ready) begin
			moved = 1'b1;
			if (expected_cells.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %h", out_data);
			end else begin
				want = expected_cells.pop_front();
				if (out_data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: result exp %h got %h, last exp %b got %b, sat exp %b got %b",
							want.result_element, out_data.result_element,
							want.last_element, out_data.last_element,
							want.saturated, out_data.saturated);
				end
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick_element();
		logic signed [31:0] corners[6];
		corners = '{Q_MAX, Q_MIN, 32'sd0, -32'sd1, 32'sd1, 32'sh0001_0000};
		case ($urandom_range(5))
			0:       return corners[$urandom_range(5)];
			1, 2:    return $signed($urandom_range(1048576)) - 32'sd524288;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_matrix();
		in_t item;
		for (int i = 0; i < CELLS; i++) begin
			item.a_element = pick_element();
			item.b_element = pick_element();
			pending_items.push_back(item);
		end
	endtask

	task automatic queue_fixed(input logic signed [31:0] a, input logic signed [31:0] b);
		in_t item;
		item.a_element = a;
		item.b_element = b;
		pending_items.push_back(item);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() > 0 || in_valid || expected_cells.size() > 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_OP_MODE)
			model_mode = value[2:0];
		else
			model_scalar = value;
	endtask

	task automatic set_mode(input logic [2:0] mode, input logic signed [31:0] scalar);
		// upper bits of the mode write are don't-care
		write_reg(REG_OP_MODE, {$urandom_range(1) ? 29'($urandom) : 29'd0, mode});
		write_reg(REG_SCALAR, scalar);
	endtask

	initial begin
		logic signed [31:0] scalar;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = 1'b0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_ready    = 1'b0;
		model_mode   = OP_MODE_RESET;
		model_scalar = SCALAR_RESET;
		loaded       = 0;
		send_idle    = 17;
		recv_idle    = 66;
		hold_request = 1'b0;
		hold_left    = 0;
		beat_taken   = 1'b0;
		mismatches   = 0;
		quiet_cycles = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: product of extreme matrices
		queue_fixed(Q_MAX, Q_MAX);
		queue_fixed(Q_MIN, Q_MIN);
		queue_fixed(Q_MIN, Q_MAX);
		queue_fixed(32'sh0001_0000, -32'sd1);
		queue_fixed(-32'sd1, 32'sh0001_0000);
		queue_fixed(0, 0);
		queue_fixed(32'sh0002_8000, 32'shFFFE_8000);
		queue_fixed(1, 1);
		queue_fixed(Q_MAX, Q_MIN);
		wait_drained();

		// element-wise add with overflow both ways
		set_mode(OP_ADD, 0);
		for (int i = 0; i < CELLS; i++)
			queue_fixed(i % 2 ? Q_MIN : Q_MAX, i % 3 ? Q_MIN : Q_MAX);
		wait_drained();

		// divide by zero: positive, zero and negative elements
		set_mode(OP_SDIV, 0);
		for (int i = 0; i < CELLS; i++)
			queue_fixed(i % 3 == 0 ? 0 : (i % 3 == 1 ? Q_MAX : -32'sd5), $urandom);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = phase == 0 ? 17 : (phase == 1 ? 66 : 0);
			recv_idle = phase == 0 ? 66 : (phase == 1 ? 17 : 0);
			for (int g = 0; g < 4; g++) begin
				case ($urandom_range(5))
					0:       scalar = Q_MAX;
					1:       scalar = Q_MIN;
					2:       scalar = 0;
					3:       scalar = $signed($urandom_range(1048576)) - 32'sd524288;
					default: scalar = $urandom;
				endcase
				set_mode(3'($urandom_range(7)), scalar);
				queue_matrix();
				// a second matrix waits behind the held results
				if (phase == 2 && g == 0) begin
					hold_request = 1'b1;
					queue_matrix();
				end
				wait_drained();
			end
		end

		// leave the unit in the full product with scalar extreme
		set_mode(OP_MMUL, Q_MIN);
		queue_matrix();
		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
